// ----- design/conv7x7_stride2_stream_defines.svh -----
// Assertion macros shared by the convolution block.
`ifndef CONV7X7_STRIDE2_STREAM_DEFINES_SVH
`define CONV7X7_STRIDE2_STREAM_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent true at a clock edge implies consequent at the same edge.
`define C7S2_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("conv7x7_stride2_stream: same-cycle check failed");

// Antecedent true at a clock edge implies consequent at the next edge.
`define C7S2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("conv7x7_stride2_stream: next-cycle check failed");

`else

`define C7S2_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define C7S2_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/c7s2_pkg.sv -----
package c7s2_pkg;

    // Kernel geometry and line storage.
    localparam int KSIZE  = 7;
    localparam int KIDX_W = 3;
    localparam int NLINES = 6;

    // Field and datapath widths.
    localparam int PIX_W    = 8;
    localparam int WT_W     = 16;
    localparam int WIDX_W   = 6;
    localparam int SIZE_W   = 9;
    localparam int COORD_W  = 7;
    localparam int PROD_W   = 24;
    localparam int ROWSUM_W = 27;
    localparam int SUM_W    = 32;

    // Image size limits and reset value.
    localparam int               SIZE_RESET = 224;
    localparam logic [SIZE_W-1:0] SIZE_MIN  = 9'd8;

    // Kind of an input word, carried on tuser.
    typedef enum logic {
        OP_WEIGHT = 1'b0,
        OP_PIXEL  = 1'b1
    } t_opcode;

    // Control handed from the top level to every cell.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              shift_en;
        logic              adv;
        logic              wt_en;
        logic [WIDX_W-1:0] wt_idx;
        logic [WT_W-1:0]   wt_val;
    } t_cell_ctrl;

endpackage

// ----- design/conv7x7_stride2_stream.sv -----
// Streaming 7x7 stride-2 convolution of one filter over a grayscale frame that
// arrives already zero-padded by three pixels on each side, in raster order.
// Input words on tuser 0 load one signed Q8.8 weight, words on tuser 1 carry one
// padded pixel; the block takes one word per clock while the skid stage is
// empty, a rate set by six line memories of MAX_IMAGE_SIZE+6 bytes, each read
// once and written once per pixel; no clearing pass is needed after reset. A
// result (signed Q24.8 sum with its output row and column, tlast on the final
// result of the frame) follows the pixel closing an even-origin window through
// its read, window, product and row-sum registers. Writing image_size (saturated
// to 8..MAX_IMAGE_SIZE, bit 0 cleared) restarts the frame and must happen only
// while no word is in flight; weights should all be loaded before a frame.
`include "conv7x7_stride2_stream_defines.svh"

module conv7x7_stride2_stream #(
    parameter int MAX_IMAGE_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: image_size.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] weight_index, [21:6] weight_value, [29:22] pixel, [31:30] zero
    input  logic [31:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] sum, [38:32] out_row, [45:39] out_col, [47:46] zero
    output logic [47:0] m_axis_tdata,
    // frame_last
    output logic        m_axis_tlast
);

    localparam int LINE_LEN = MAX_IMAGE_SIZE + c7s2_pkg::NLINES;
    localparam int AW       = $clog2(LINE_LEN);
    localparam int CW       = $clog2(LINE_LEN + 1);
    localparam int SIZE_CAP = (c7s2_pkg::SIZE_RESET > MAX_IMAGE_SIZE) ?
                              MAX_IMAGE_SIZE : c7s2_pkg::SIZE_RESET;
    localparam logic [c7s2_pkg::SIZE_W-1:0] SIZE_RST =
        c7s2_pkg::SIZE_W'(SIZE_CAP / 2 * 2);

    // Input word fields.
    c7s2_pkg::t_opcode                 w_op;
    logic [c7s2_pkg::WIDX_W-1:0]       w_widx;
    logic [c7s2_pkg::WT_W-1:0]         w_wval;
    logic [c7s2_pkg::PIX_W-1:0]        w_pix;
    logic                              w_in_acc;
    logic                              w_adv;

    // Frame position and size.
    logic [c7s2_pkg::SIZE_W-1:0]       r_size;
    logic [c7s2_pkg::SIZE_W-1:0]       w_cfg_sat;
    logic [CW-1:0]                     r_row_cnt;
    logic [CW-1:0]                     r_col_cnt;
    logic [CW-1:0]                     w_pad;
    logic                              w_emit;
    logic                              w_last;
    logic [c7s2_pkg::COORD_W-1:0]      w_orow;
    logic [c7s2_pkg::COORD_W-1:0]      w_ocol;

    // Pipeline stages.
    logic                              r_v1, r_v2, r_v3, r_v4;
    c7s2_pkg::t_opcode                 r_op1, r_op2;
    logic                              r_emit1, r_emit2;
    logic                              r_last1, r_last2, r_last3, r_last4;
    logic [c7s2_pkg::COORD_W-1:0]      r_orow1, r_orow2, r_orow3, r_orow4;
    logic [c7s2_pkg::COORD_W-1:0]      r_ocol1, r_ocol2, r_ocol3, r_ocol4;
    logic [AW-1:0]                     r_addr1;
    logic [c7s2_pkg::WIDX_W-1:0]       r_widx1, r_widx2;
    logic [c7s2_pkg::WT_W-1:0]         r_wval1, r_wval2;

    // Cell chain.
    c7s2_pkg::t_cell_ctrl              w_ctrl;
    logic [c7s2_pkg::PIX_W-1:0]        w_col    [c7s2_pkg::KSIZE];
    logic [c7s2_pkg::PIX_W-1:0]        w_nb     [c7s2_pkg::KSIZE];
    logic [c7s2_pkg::ROWSUM_W-1:0]     w_rowsum [c7s2_pkg::KSIZE];
    logic [c7s2_pkg::SUM_W-1:0]        w_total;

    // Output register and skid stage.
    logic                              r_out_valid, r_skid_valid;
    logic [c7s2_pkg::SUM_W-1:0]        r_out_sum, r_skid_sum;
    logic [c7s2_pkg::COORD_W-1:0]      r_out_row, r_skid_row;
    logic [c7s2_pkg::COORD_W-1:0]      r_out_col, r_skid_col;
    logic                              r_out_last, r_skid_last;
    logic                              w_out_take;

    // Unpack the input word.
    assign w_op   = c7s2_pkg::t_opcode'(s_axis_tuser);
    assign w_widx = s_axis_tdata[5:0];
    assign w_wval = s_axis_tdata[21:6];
    assign w_pix  = s_axis_tdata[29:22];

    // The whole pipeline moves while the skid stage is empty.
    assign w_adv         = !r_skid_valid;
    assign s_axis_tready = w_adv;
    assign w_in_acc      = s_axis_tvalid && w_adv;
    assign o_cfg_ready   = 1'b1;

    // Saturate a written image size and clear bit 0.
    always_comb begin
        logic [c7s2_pkg::SIZE_W-1:0] v;
        if (i_cfg_data < c7s2_pkg::SIZE_MIN) begin
            v = c7s2_pkg::SIZE_MIN;
        end else if (32'(i_cfg_data) > MAX_IMAGE_SIZE) begin
            v = c7s2_pkg::SIZE_W'(MAX_IMAGE_SIZE);
        end else begin
            v = i_cfg_data;
        end
        w_cfg_sat = {v[c7s2_pkg::SIZE_W-1:1], 1'b0};
    end

    // Window completion test for the pixel now at the input.
    assign w_pad  = CW'(r_size) + CW'(c7s2_pkg::NLINES);
    assign w_emit = (r_row_cnt >= CW'(c7s2_pkg::NLINES)) &&
                    (r_col_cnt >= CW'(c7s2_pkg::NLINES)) &&
                    !r_row_cnt[0] && !r_col_cnt[0] &&
                    (r_row_cnt < w_pad) && (r_col_cnt < w_pad);
    assign w_last = (r_row_cnt == w_pad - CW'(2)) && (r_col_cnt == w_pad - CW'(2));
    assign w_orow = c7s2_pkg::COORD_W'((r_row_cnt - CW'(c7s2_pkg::NLINES)) >> 1);
    assign w_ocol = c7s2_pkg::COORD_W'((r_col_cnt - CW'(c7s2_pkg::NLINES)) >> 1);

    // Image size and raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_RST;
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (i_cfg_valid) begin
            r_size    <= w_cfg_sat;
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (w_in_acc && (w_op == c7s2_pkg::OP_PIXEL)) begin
            if (r_col_cnt + CW'(1) >= w_pad) begin
                r_col_cnt <= '0;
                r_row_cnt <= (r_row_cnt + CW'(1) >= w_pad) ? '0 : r_row_cnt + CW'(1);
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_in_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && (r_op2 == c7s2_pkg::OP_PIXEL) && r_emit2;
            r_v4 <= r_v3;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1   <= w_op;
            r_emit1 <= w_emit;
            r_last1 <= w_last;
            r_orow1 <= w_orow;
            r_ocol1 <= w_ocol;
            r_addr1 <= r_col_cnt[AW-1:0];
            r_widx1 <= w_widx;
            r_wval1 <= w_wval;

            r_op2   <= r_op1;
            r_emit2 <= r_emit1;
            r_last2 <= r_last1;
            r_orow2 <= r_orow1;
            r_ocol2 <= r_ocol1;
            r_widx2 <= r_widx1;
            r_wval2 <= r_wval1;

            r_last3 <= r_last2;
            r_orow3 <= r_orow2;
            r_ocol3 <= r_ocol2;

            r_last4 <= r_last3;
            r_orow4 <= r_orow3;
            r_ocol4 <= r_ocol3;
        end
    end

    // Cell control. A weight is written when its word leaves stage two, so
    // earlier pixels have already taken their products.
    always_comb begin
        w_ctrl.rd_en    = w_in_acc && (w_op == c7s2_pkg::OP_PIXEL);
        w_ctrl.wr_en    = w_adv && r_v1 && (r_op1 == c7s2_pkg::OP_PIXEL);
        w_ctrl.shift_en = w_adv && r_v1 && (r_op1 == c7s2_pkg::OP_PIXEL);
        w_ctrl.adv      = w_adv;
        w_ctrl.wt_en    = w_adv && r_v2 && (r_op2 == c7s2_pkg::OP_WEIGHT);
        w_ctrl.wt_idx   = r_widx2;
        w_ctrl.wt_val   = r_wval2;
    end

    // Chain of row cells, oldest row first; each line takes the next row's column.
    generate
        for (genvar k = 0; k < c7s2_pkg::KSIZE; k++) begin : g_cell
            if (k == c7s2_pkg::NLINES) begin : g_nb_pix
                assign w_nb[k] = w_pix;
            end else begin : g_nb_row
                assign w_nb[k] = w_col[k + 1];
            end

            c7s2_cell #(
                .ROW      (k),
                .HAS_LINE (k < c7s2_pkg::NLINES),
                .DEPTH    (LINE_LEN)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (w_ctrl),
                .i_rd_addr (r_col_cnt[AW-1:0]),
                .i_wr_addr (r_addr1),
                .i_nb_col  (w_nb[k]),
                .o_col     (w_col[k]),
                .o_row_sum (w_rowsum[k])
            );
        end
    endgenerate

    // Final sum of the seven row sums.
    always_comb begin
        w_total = '0;
        for (int k = 0; k < c7s2_pkg::KSIZE; k++) begin
            w_total = w_total +
                {{(c7s2_pkg::SUM_W - c7s2_pkg::ROWSUM_W){w_rowsum[k][c7s2_pkg::ROWSUM_W-1]}},
                 w_rowsum[k]};
        end
    end

    assign w_out_take = r_out_valid && m_axis_tready;

    // Output and skid valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_v4) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output and skid payload.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out_sum  <= r_skid_sum;
                r_out_row  <= r_skid_row;
                r_out_col  <= r_skid_col;
                r_out_last <= r_skid_last;
            end
        end else if (r_v4) begin
            if (!r_out_valid || w_out_take) begin
                r_out_sum  <= w_total;
                r_out_row  <= r_orow4;
                r_out_col  <= r_ocol4;
                r_out_last <= r_last4;
            end else begin
                r_skid_sum  <= w_total;
                r_skid_row  <= r_orow4;
                r_skid_col  <= r_ocol4;
                r_skid_last <= r_last4;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_col, r_out_row, r_out_sum};
    assign m_axis_tlast  = r_out_last;

    // The raster column never reaches the padded width.
    `C7S2_ASSERT_IMPLIES(a_col_in_frame, i_clk, i_rst_n, 1'b1, r_col_cnt < w_pad)
    // A word waits in the skid stage only behind a word in the output register.
    `C7S2_ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    // When the output word is taken with the skid stage full, the skid word follows.
    `C7S2_ASSERT_NEXT(a_skid_moves_up, i_clk, i_rst_n, r_skid_valid && m_axis_tready, m_axis_tvalid)
    // The final window of a frame lies on the diagonal.
    `C7S2_ASSERT_IMPLIES(a_last_diag, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, r_out_row == r_out_col)

endmodule

// ----- design/c7s2_cell.sv -----
// One kernel row: a line memory (except for the newest row), a seven-pixel
// window row, its seven weights, the products and the registered row sum.
module c7s2_cell #(
    parameter int ROW      = 0,
    parameter bit HAS_LINE = 1'b1,
    parameter int DEPTH    = 262
) (
    input  logic                              i_clk,
    input  c7s2_pkg::t_cell_ctrl              i_ctrl,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic [c7s2_pkg::PIX_W-1:0]        i_nb_col,
    output logic [c7s2_pkg::PIX_W-1:0]        o_col,
    output logic [c7s2_pkg::ROWSUM_W-1:0]     o_row_sum
);

    localparam logic [c7s2_pkg::WIDX_W-1:0] BASE =
        c7s2_pkg::WIDX_W'(ROW * c7s2_pkg::KSIZE);

    logic [c7s2_pkg::PIX_W-1:0]    r_col;
    logic [c7s2_pkg::PIX_W-1:0]    r_win  [c7s2_pkg::KSIZE];
    logic [c7s2_pkg::WT_W-1:0]     r_wt   [c7s2_pkg::KSIZE];
    logic [c7s2_pkg::PROD_W-1:0]   r_prod [c7s2_pkg::KSIZE];
    logic [c7s2_pkg::PROD_W-1:0]   w_prod [c7s2_pkg::KSIZE];
    logic [c7s2_pkg::ROWSUM_W-1:0] r_sum;
    logic [c7s2_pkg::ROWSUM_W-1:0] w_sum;
    logic                          w_wt_hit;
    logic [c7s2_pkg::KIDX_W-1:0]   w_wt_sel;

    // Column value of this row: the stored line, or the incoming pixel.
    generate
        if (HAS_LINE) begin : g_line
            logic [c7s2_pkg::PIX_W-1:0] r_mem [DEPTH];

            always_ff @(posedge i_clk) begin
                if (i_ctrl.wr_en) begin
                    r_mem[i_wr_addr] <= i_nb_col;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_ctrl.rd_en) begin
                    r_col <= r_mem[i_rd_addr];
                end
            end
        end else begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_ctrl.rd_en) begin
                    r_col <= i_nb_col;
                end
            end
        end
    endgenerate

    // Window row shifts left and takes the new column value on the right.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_en) begin
            for (int j = 0; j < c7s2_pkg::KSIZE - 1; j++) begin
                r_win[j] <= r_win[j + 1];
            end
            r_win[c7s2_pkg::KSIZE - 1] <= r_col;
        end
    end

    // Weight load addressed to this row.
    assign w_wt_hit = i_ctrl.wt_en && (i_ctrl.wt_idx >= BASE) &&
                      (i_ctrl.wt_idx < BASE + c7s2_pkg::WIDX_W'(c7s2_pkg::KSIZE));
    assign w_wt_sel = c7s2_pkg::KIDX_W'(i_ctrl.wt_idx - BASE);

    always_ff @(posedge i_clk) begin
        if (w_wt_hit) begin
            r_wt[w_wt_sel] <= i_ctrl.wt_val;
        end
    end

    // Unsigned pixel times signed weight, both extended to the product width.
    always_comb begin
        for (int j = 0; j < c7s2_pkg::KSIZE; j++) begin
            w_prod[j] = {{(c7s2_pkg::PROD_W - c7s2_pkg::PIX_W){1'b0}}, r_win[j]} *
                        {{(c7s2_pkg::PROD_W - c7s2_pkg::WT_W){r_wt[j][c7s2_pkg::WT_W-1]}},
                         r_wt[j]};
        end
    end

    // Sum of the seven registered products.
    always_comb begin
        w_sum = '0;
        for (int j = 0; j < c7s2_pkg::KSIZE; j++) begin
            w_sum = w_sum +
                    {{(c7s2_pkg::ROWSUM_W - c7s2_pkg::PROD_W){r_prod[j][c7s2_pkg::PROD_W-1]}},
                     r_prod[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            for (int j = 0; j < c7s2_pkg::KSIZE; j++) begin
                r_prod[j] <= w_prod[j];
            end
            r_sum <= w_sum;
        end
    end

    assign o_col     = r_col;
    assign o_row_sum = r_sum;

endmodule

// ----- dv/tb.sv -----
module tb;

    localparam int MAX_SIZE     = 256;
    localparam int LINE_LEN     = MAX_SIZE + 6;
    localparam int NTAPS        = c7s2_pkg::KSIZE * c7s2_pkg::KSIZE;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // One expected window sum with its output coordinates.
    typedef struct {
        logic [c7s2_pkg::SUM_W-1:0]   sum;
        logic [c7s2_pkg::COORD_W-1:0] row;
        logic [c7s2_pkg::COORD_W-1:0] col;
        logic                         last;
    } t_window_sum;

    // Convolution predictor and result checker.
    class conv_scoreboard;
        int unsigned                size;
        logic [c7s2_pkg::PIX_W-1:0] lines [c7s2_pkg::NLINES][LINE_LEN];
        logic [c7s2_pkg::WT_W-1:0]  taps [NTAPS];
        logic [c7s2_pkg::PIX_W-1:0] win [c7s2_pkg::KSIZE][c7s2_pkg::KSIZE];
        int unsigned                row_cnt;
        int unsigned                col_cnt;
        t_window_sum                pending_sums [$];
        int unsigned                mismatches;

        function new();
            size = c7s2_pkg::SIZE_RESET;
            foreach (lines[i, j]) lines[i][j] = '0;
            foreach (taps[i]) taps[i] = '0;
            mismatches = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            row_cnt = 0;
            col_cnt = 0;
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        // The written side is clamped to the legal range and made even.
        function void set_size(logic [c7s2_pkg::SIZE_W-1:0] value);
            int unsigned v;
            v = value;
            if (v < c7s2_pkg::SIZE_MIN) v = c7s2_pkg::SIZE_MIN;
            if (v > MAX_SIZE) v = MAX_SIZE;
            size = v & ~32'd1;
            restart_frame();
        endfunction

        // Update the state for one accepted input word and queue any window sum.
        function void note_word(c7s2_pkg::t_opcode op, logic [c7s2_pkg::WIDX_W-1:0] idx,
                                logic [c7s2_pkg::WT_W-1:0] wval,
                                logic [c7s2_pkg::PIX_W-1:0] pix);
            int unsigned                padded;
            int unsigned                r;
            int unsigned                c;
            int                         ky;
            int                         kx;
            logic [c7s2_pkg::PIX_W-1:0] column [c7s2_pkg::KSIZE];
            longint                     acc;
            t_window_sum                res;
            if (op == c7s2_pkg::OP_WEIGHT) begin
                if (idx < NTAPS) taps[idx] = wval;
                return;
            end
            padded = size + 6;
            r = row_cnt;
            c = col_cnt;

            // Pull the column out of the line stores and push the new pixel in.
            for (ky = 0; ky < c7s2_pkg::NLINES; ky++) column[ky] = lines[ky][c];
            column[c7s2_pkg::NLINES] = pix;
            for (ky = 0; ky < c7s2_pkg::NLINES - 1; ky++) lines[ky][c] = lines[ky + 1][c];
            lines[c7s2_pkg::NLINES - 1][c] = pix;
            for (ky = 0; ky < c7s2_pkg::KSIZE; ky++) begin
                for (kx = 0; kx < c7s2_pkg::KSIZE - 1; kx++) win[ky][kx] = win[ky][kx + 1];
                win[ky][c7s2_pkg::KSIZE - 1] = column[ky];
            end

            // A window completes only at an even origin inside the image.
            if (r >= 6 && c >= 6 && ((r - 6) % 2) == 0 && ((c - 6) % 2) == 0 &&
                (r - 6) < size && (c - 6) < size) begin
                acc = 0;
                for (ky = 0; ky < c7s2_pkg::KSIZE; ky++)
                    for (kx = 0; kx < c7s2_pkg::KSIZE; kx++)
                        acc += longint'(win[ky][kx]) *
                               longint'($signed(taps[ky * c7s2_pkg::KSIZE + kx]));
                res.sum  = acc[c7s2_pkg::SUM_W-1:0];
                res.row  = c7s2_pkg::COORD_W'((r - 6) >> 1);
                res.col  = c7s2_pkg::COORD_W'((c - 6) >> 1);
                res.last = (r == size + 4 && c == size + 4);
                pending_sums.push_back(res);
            end

            if (c + 1 >= padded) begin
                col_cnt = 0;
                row_cnt = (r + 1 >= padded) ? 0 : r + 1;
            end else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_result(logic [47:0] data, logic last);
            t_window_sum want;
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Unexpected result: sum %0d row %0d col %0d last %0b",
                             $signed(data[31:0]), data[38:32], data[45:39], last);
                return;
            end
            want = pending_sums.pop_front();
            if (data[31:0] !== want.sum || data[38:32] !== want.row ||
                data[45:39] !== want.col || last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("Mismatch: expected sum %0d row %0d col %0d last %0b,",
                             $signed(want.sum), want.row, want.col, want.last,
                             " got sum %0d row %0d col %0d last %0b",
                             $signed(data[31:0]), data[38:32], data[45:39], last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    conv_scoreboard sb;
    t_idle_mode     idle_mode = IDLE_NONE;
    int unsigned    cycles = 0;

    conv7x7_stride2_stream #(
        .MAX_IMAGE_SIZE(MAX_SIZE)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // Clock with a period of ten.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge.
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECV: m_axis_tready <= ($urandom_range(99) >= 55);
            IDLE_BOTH: m_axis_tready <= ($urandom_range(99) >= 18);
            default:   m_axis_tready <= 1'b1;
        endcase
    end

    // Handshake monitor: results are checked and inputs noted at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_size(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(c7s2_pkg::t_opcode'(s_axis_tuser), s_axis_tdata[5:0],
                             s_axis_tdata[21:6], s_axis_tdata[29:22]);
        end
    end

    // Present one input word, with random sender gaps ahead of it.
    task automatic send_word(input c7s2_pkg::t_opcode op,
                             input logic [c7s2_pkg::WIDX_W-1:0] idx,
                             input logic [c7s2_pkg::WT_W-1:0] wval,
                             input logic [c7s2_pkg::PIX_W-1:0] pix);
        int unsigned gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 18 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {2'b00, pix, wval, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid = 1'b0;
        while (sb.pending_sums.size() != 0) @(negedge i_clk);
    endtask

    // The block must be idle for a size write; pixels with no result may still be in flight.
    task automatic write_size(input logic [c7s2_pkg::SIZE_W-1:0] value);
        wait_results_done();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Load all 49 taps, either with one value or randomly with the extremes mixed in.
    task automatic load_taps(input bit use_const, input logic [c7s2_pkg::WT_W-1:0] const_val);
        int                        t;
        logic [c7s2_pkg::WT_W-1:0] w;
        for (t = 0; t < NTAPS; t++) begin
            case ($urandom_range(7))
                0:       w = 16'h8000;
                1:       w = 16'h7fff;
                2:       w = 16'h0000;
                3:       w = 16'hffff;
                default: w = c7s2_pkg::WT_W'($urandom);
            endcase
            if (use_const) w = const_val;
            send_word(c7s2_pkg::OP_WEIGHT, c7s2_pkg::WIDX_W'(t), w,
                      c7s2_pkg::PIX_W'($urandom));
        end
    endtask

    // Random pixels with occasional tap reloads and ignored tap indexes.
    task automatic stream_random(input int unsigned n_pixels, input bit hold_off);
        int unsigned                sent;
        int unsigned                pick;
        logic [c7s2_pkg::PIX_W-1:0] pix;
        sent = 0;
        while (sent < n_pixels) begin
            if (hold_off && sent == n_pixels / 2) begin
                wait_results_done();
                hold_off = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_word(c7s2_pkg::OP_WEIGHT, c7s2_pkg::WIDX_W'($urandom_range(NTAPS - 1)),
                          c7s2_pkg::WT_W'($urandom), c7s2_pkg::PIX_W'($urandom));
            end else if (pick < 7) begin
                send_word(c7s2_pkg::OP_WEIGHT, c7s2_pkg::WIDX_W'($urandom_range(63, NTAPS)),
                          c7s2_pkg::WT_W'($urandom), c7s2_pkg::PIX_W'($urandom));
            end else begin
                case ($urandom_range(9))
                    0:       pix = 8'h00;
                    1:       pix = 8'hff;
                    default: pix = c7s2_pkg::PIX_W'($urandom);
                endcase
                send_word(c7s2_pkg::OP_PIXEL, c7s2_pkg::WIDX_W'($urandom),
                          c7s2_pkg::WT_W'($urandom), pix);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input t_idle_mode mode,
                             input logic [c7s2_pkg::SIZE_W-1:0] size_val,
                             input int unsigned n_pixels, input bit hold_off);
        write_size(size_val);
        idle_mode = mode;
        load_taps(1'b0, '0);
        stream_random(n_pixels, hold_off);
    endtask

    initial begin
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = c7s2_pkg::OP_WEIGHT;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset size: taps with extremes, ignored indexes, then a stretch of pixels
        // that is too short to complete any window of the reset frame.
        load_taps(1'b0, '0);
        send_word(c7s2_pkg::OP_WEIGHT, 6'd49, 16'hffff, 8'hff);
        send_word(c7s2_pkg::OP_WEIGHT, 6'd63, 16'h8000, 8'h00);
        stream_random(100, 1'b0);

        // Smallest frame with every pixel at full scale and every tap at each extreme.
        idle_mode = IDLE_NONE;
        write_size(9'd8);
        load_taps(1'b1, 16'h8000);
        repeat (14 * 14) send_word(c7s2_pkg::OP_PIXEL, '0, '0, 8'hff);
        load_taps(1'b1, 16'h7fff);
        repeat (14 * 14) send_word(c7s2_pkg::OP_PIXEL, '1, '1, 8'hff);

        // Random phases over several sizes, odd and out-of-range writes among them.
        // The held phase pauses right after a pixel that completes a window.
        run_phase(IDLE_SEND, 9'd5,   200, 1'b0);
        run_phase(IDLE_RECV, 9'd11,  200, 1'b0);
        run_phase(IDLE_BOTH, 9'd9,   200, 1'b0);
        run_phase(IDLE_NONE, 9'd0,   194, 1'b1);
        run_phase(IDLE_RECV, 9'd511, 40,  1'b0);

        wait_results_done();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
